// ===== rtl/q24_pkg.sv =====
// Shared definitions for the Q24.8 fixed-point arithmetic unit.
// Holds action codes, op class codes, the op class struct and default sizes.
// No dependencies.
`default_nettype none

package q24_pkg;

	localparam int ACTION_W = 4;

	localparam logic [ACTION_W-1:0] ACT_ADD      = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_SUB      = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_MUL      = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_DIV      = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_GT       = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_LT       = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_GE       = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_LE       = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_EQ       = 4'd8;
	localparam logic [ACTION_W-1:0] ACT_NE       = 4'd9;
	localparam logic [ACTION_W-1:0] ACT_MIN      = 4'd10;
	localparam logic [ACTION_W-1:0] ACT_MAX      = 4'd11;
	localparam logic [ACTION_W-1:0] ACT_INC      = 4'd12;
	localparam logic [ACTION_W-1:0] ACT_DEC      = 4'd13;
	localparam logic [ACTION_W-1:0] ACT_TO_INT   = 4'd14;
	localparam logic [ACTION_W-1:0] ACT_FROM_INT = 4'd15;

	localparam logic [1:0] KIND_SIMPLE = 2'd0;
	localparam logic [1:0] KIND_MUL    = 2'd1;
	localparam logic [1:0] KIND_DIV    = 2'd2;

	localparam int DEF_FRAC_BITS  = 8;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic [1:0] kind;
		logic       cmp;
		logic       err;
		logic       neg;
	} op_class_t;

	localparam int CLASS_W = $bits(op_class_t);

endpackage

`default_nettype wire

// ===== rtl/q24_front.sv =====
// Front end: accepts input words, decodes the action and finishes the
// simple operations; mul/div get operand magnitudes. Uses q24_pkg.
`default_nettype none

module q24_front
	import q24_pkg::*;
#(
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int IN_DATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
	parameter int ENTRY_W    = CLASS_W + 3 * DATA_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic [ACTION_W-1:0]  s_tuser,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [ENTRY_W-1:0]        out_data
);

	localparam int W = DATA_WIDTH;

	logic signed [W-1:0] a, b;
	logic                lt_ab, lt_ba;
	logic [W-1:0]        simple, ma, mb;
	op_class_t           cls;
	logic                fr_valid_s1;
	logic [ENTRY_W-1:0]  entry_s1;

	assign a     = s_tdata[W-1:0];
	assign b     = s_tdata[2*W-1:W];
	assign lt_ab = a < b;
	assign lt_ba = b < a;
	assign ma    = a[W-1] ? W'(-a) : W'(a);
	assign mb    = b[W-1] ? W'(-b) : W'(b);

	always_comb begin
		cls      = '0;
		cls.neg  = a[W-1] ^ b[W-1];
		simple   = '0;
		unique case (s_tuser)
			ACT_ADD: simple = W'(a + b);
			ACT_SUB: simple = W'(a - b);
			ACT_MUL: cls.kind = KIND_MUL;
			ACT_DIV: begin
				if (b == '0) cls.err = 1'b1;
				else cls.kind = KIND_DIV;
			end
			ACT_GT: cls.cmp = lt_ba;
			ACT_LT: cls.cmp = lt_ab;
			ACT_GE: cls.cmp = !lt_ab;
			ACT_LE: cls.cmp = !lt_ba;
			ACT_EQ: cls.cmp = (a == b);
			ACT_NE: cls.cmp = (a != b);
			ACT_MIN: simple = lt_ba ? b : a;
			ACT_MAX: simple = lt_ba ? a : b;
			ACT_INC: simple = W'(a + {{(W-1){1'b0}}, 1'b1});
			ACT_DEC: simple = W'(a - {{(W-1){1'b0}}, 1'b1});
			ACT_TO_INT: simple = W'(a >>> FRAC_BITS);
			ACT_FROM_INT: simple = W'(a << FRAC_BITS);
			default: simple = '0;
		endcase
	end

	assign s_tready  = !fr_valid_s1 || out_ready;
	assign out_valid = fr_valid_s1;
	assign out_data  = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			fr_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			entry_s1 <= {cls, simple, ma, mb};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/q24_queue.sv =====
// Short FIFO between front and back end so each side stalls on its own.
// Uses q24_pkg for the default depth.
`default_nettype none

module q24_queue
	import q24_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign in_ready  = cnt_q != FULL;
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_data;
	end

endmodule

`default_nettype wire

// ===== rtl/q24_back.sv =====
// Back end: multiplier and pipelined restoring divider (one quotient bit per
// stage), round/saturate stage and the output register. Uses q24_pkg.
`default_nettype none

module q24_back
	import q24_pkg::*;
#(
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int ENTRY_W    = CLASS_W + 3 * DATA_WIDTH,
	parameter int OUT_DATA_W = ((DATA_WIDTH + 2 + 7) / 8) * 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [ENTRY_W-1:0] in_data,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [OUT_DATA_W-1:0]   m_tdata
);

	localparam int W  = DATA_WIDTH;
	localparam int N  = DATA_WIDTH + FRAC_BITS;
	localparam int PW = 2 * DATA_WIDTH + 1;
	localparam logic [PW-1:0] HALF    = PW'(1) << (FRAC_BITS - 1);
	localparam logic [W-1:0]  POS_LIM = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  NEG_LIM = {1'b1, {(W-1){1'b0}}};

	op_class_t    in_cls;
	logic [W-1:0] in_simple, in_ma, in_mb;
	logic         en;

	assign {in_cls, in_simple, in_ma, in_mb} = in_data;
	assign en       = !m_tvalid || m_tready;
	assign in_ready = en;

	// divider stages
	logic         v_s1      [N];
	op_class_t    cls_s1    [N];
	logic [W-1:0] simple_s1 [N];
	logic [W-1:0] den_s1    [N];
	logic [W-1:0] rem_s1    [N];
	logic [N-1:0] nq_s1     [N];
	logic [2*W-1:0] prod_s1 [N];

	logic [W-1:0] den_src [N];
	logic [W-1:0] rem_src [N];
	logic [N-1:0] nq_src  [N];
	logic [W:0]   rem2    [N];
	logic         ge      [N];
	logic [W-1:0] rem_nx  [N];
	logic [N-1:0] nq_nx   [N];

	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				den_src[k] = in_mb;
				rem_src[k] = '0;
				nq_src[k]  = {in_ma, {FRAC_BITS{1'b0}}};
			end else begin
				den_src[k] = den_s1[k-1];
				rem_src[k] = rem_s1[k-1];
				nq_src[k]  = nq_s1[k-1];
			end
			rem2[k]   = {rem_src[k], nq_src[k][N-1]};
			ge[k]     = rem2[k] >= {1'b0, den_src[k]};
			rem_nx[k] = ge[k] ? W'(rem2[k] - {1'b0, den_src[k]}) : rem2[k][W-1:0];
			nq_nx[k]  = {nq_src[k][N-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) v_s1[k] <= 1'b0;
		end else if (en) begin
			v_s1[0] <= in_valid;
			for (int k = 1; k < N; k++) v_s1[k] <= v_s1[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1[0]    <= in_cls;
			simple_s1[0] <= in_simple;
			prod_s1[0]   <= {{W{1'b0}}, in_ma} * {{W{1'b0}}, in_mb};
			for (int k = 1; k < N; k++) begin
				cls_s1[k]    <= cls_s1[k-1];
				simple_s1[k] <= simple_s1[k-1];
				prod_s1[k]   <= prod_s1[k-1];
			end
			for (int k = 0; k < N; k++) begin
				den_s1[k] <= den_src[k];
				rem_s1[k] <= rem_nx[k];
				nq_s1[k]  <= nq_nx[k];
			end
		end
	end

	// round half away from zero and clamp the magnitude
	logic [PW-1:0] mul_mag;
	logic [N:0]    div_mag;
	logic          div_up;
	logic [W-1:0]  lim, mag;
	op_class_t     last_cls;

	assign last_cls = cls_s1[N-1];
	assign lim      = last_cls.neg ? NEG_LIM : POS_LIM;
	assign mul_mag  = ({1'b0, prod_s1[N-1]} + HALF) >> FRAC_BITS;
	assign div_up   = {rem_s1[N-1], 1'b0} >= {1'b0, den_s1[N-1]};
	assign div_mag  = {1'b0, nq_s1[N-1]} + {{N{1'b0}}, div_up};

	always_comb begin
		if (last_cls.kind == KIND_MUL)
			mag = (mul_mag > {{(PW-W){1'b0}}, lim}) ? lim : mul_mag[W-1:0];
		else
			mag = (div_mag > {{(N+1-W){1'b0}}, lim}) ? lim : div_mag[W-1:0];
	end

	logic         v_s2;
	op_class_t    cls_s2;
	logic [W-1:0] simple_s2, mag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s2     <= v_s1[N-1];
			m_tvalid <= v_s2;
		end
	end

	logic [W-1:0] result;

	assign result = (cls_s2.kind == KIND_SIMPLE) ? simple_s2 :
		(cls_s2.neg ? W'(-mag_s2) : mag_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s2    <= last_cls;
			simple_s2 <= simple_s1[N-1];
			mag_s2    <= mag;
			m_tdata   <= {{(OUT_DATA_W-W-2){1'b0}}, cls_s2.err, cls_s2.cmp, result};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/q24_8_fixed_point_alu_top.sv =====
// Top level of the Q24.8 fixed-point arithmetic unit.
// Instantiates q24_front, q24_queue and q24_back; uses q24_pkg.
`default_nettype none

// Signed fixed-point unit (DATA_WIDTH bits, FRAC_BITS fraction bits). Each
// input word carries the action in s_tuser and operands a and b in s_tdata;
// each output word carries the raw result, the compare flag and the divide
// error flag. Add, sub, inc, dec and from-int wrap; multiply and divide round
// half away from zero and saturate; divide by zero returns zero with the
// error flag set; comparisons return zero with the outcome in compare_true.
// One word is accepted per cycle while s_tready is high, and results leave
// in input order. Each word passes the front decode register, the queue,
// one divider stage per quotient bit, the round/saturate register and the
// output register. All ops ride the same fixed-depth pipeline, and a stall
// on m_tready holds the whole back end while the two-word queue and the
// front register soak up three more words before s_tready drops.
module q24_8_fixed_point_alu_top
	import q24_pkg::*;
#(
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int IN_DATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
	parameter int OUT_DATA_W = ((DATA_WIDTH + 2 + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// operand_a, operand_b
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  wire logic [ACTION_W-1:0]   s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// result_value, compare_true, divide_error, zero pad
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	localparam int ENTRY_W = CLASS_W + 3 * DATA_WIDTH;

	logic               fr_valid, q_in_ready;
	logic [ENTRY_W-1:0] fr_data, q_data;
	logic               q_valid, bk_ready;

	// decode and finish the simple ops
	q24_front #(
		.FRAC_BITS (FRAC_BITS),
		.DATA_WIDTH(DATA_WIDTH),
		.IN_DATA_W (IN_DATA_W),
		.ENTRY_W   (ENTRY_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.out_valid(fr_valid),
		.out_ready(q_in_ready),
		.out_data (fr_data)
	);

	// decouple the two halves
	q24_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (q_in_ready),
		.in_data  (fr_data),
		.out_valid(q_valid),
		.out_ready(bk_ready),
		.out_data (q_data)
	);

	// multiply, divide, round, saturate, drive the output
	q24_back #(
		.FRAC_BITS (FRAC_BITS),
		.DATA_WIDTH(DATA_WIDTH),
		.ENTRY_W   (ENTRY_W),
		.OUT_DATA_W(OUT_DATA_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(q_valid),
		.in_ready(bk_ready),
		.in_data (q_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

`ifndef SYNTH
	// a stalled output must freeze the back end
	a_stall_holds_back: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !bk_ready)
		else $error("back end advanced while output stalled");

	// input backpressure only comes from a full queue
	a_front_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (fr_valid && !q_in_ready))
		else $error("input stalled without a full queue");

	// a word blocked at the queue is still there next cycle
	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fr_valid && !q_in_ready) |=> fr_valid)
		else $error("front word dropped while queue full");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the Q24.8 fixed-point arithmetic unit: directed corner words,
// then random bursts with output stalls, checked against an in-bench model.
// Depends on q24_pkg and q24_8_fixed_point_alu_top.
module testbench;
	import q24_pkg::*;

	localparam int DW = 32;
	localparam int FB = 8;
	localparam int LATENCY = DW + FB + 4;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_WORDS = 1300;
	localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] MAX_NEG = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] value;
		logic        cmp;
		logic        err;
	} alu_result_t;

	// Multiply two raw values: exact product, round half away, saturate.
	function automatic logic [31:0] fx_multiply(logic signed [31:0] a, logic signed [31:0] b);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] q;
		neg = a[31] ^ b[31];
		mag = 64'(a[31] ? -64'(a) : 64'(a)) * 64'(b[31] ? -64'(b) : 64'(b));
		q = (mag + (64'd1 << (FB - 1))) >> FB;
		if (neg)
			return (q > 64'(MAX_NEG)) ? MAX_NEG : 32'(-q);
		return (q > 64'(MAX_POS)) ? MAX_POS : q[31:0];
	endfunction

	// Divide raw values with rounding half away from zero; b is nonzero.
	function automatic logic [31:0] fx_divide(logic signed [31:0] a, logic signed [31:0] b);
		logic        neg;
		logic [71:0] num;
		logic [71:0] den;
		logic [71:0] q;
		logic [71:0] r;
		neg = a[31] ^ b[31];
		num = 72'(a[31] ? -64'(a) : 64'(a)) << FB;
		den = 72'(b[31] ? -64'(b) : 64'(b));
		q = num / den;
		r = num % den;
		if (r >= den - r)
			q = q + 1;
		if (neg)
			return (q > 72'(MAX_NEG)) ? MAX_NEG : 32'(-q);
		return (q > 72'(MAX_POS)) ? MAX_POS : q[31:0];
	endfunction

	function automatic alu_result_t alu_predict(logic [3:0] act, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_result_t res;
		res = '0;
		case (act)
			ACT_ADD: res.value = a + b;
			ACT_SUB: res.value = a - b;
			ACT_MUL: res.value = fx_multiply(a, b);
			ACT_DIV: begin
				if (b == 0)
					res.err = 1'b1;
				else
					res.value = fx_divide(a, b);
			end
			ACT_GT: res.cmp = a > b;
			ACT_LT: res.cmp = a < b;
			ACT_GE: res.cmp = a >= b;
			ACT_LE: res.cmp = a <= b;
			ACT_EQ: res.cmp = a == b;
			ACT_NE: res.cmp = a != b;
			ACT_MIN: res.value = (b < a) ? b : a;
			ACT_MAX: res.value = (b < a) ? a : b;
			ACT_INC: res.value = a + 1;
			ACT_DEC: res.value = a - 1;
			ACT_TO_INT: res.value = a >>> FB;
			default: res.value = a << FB;
		endcase
		return res;
	endfunction

	class alu_scoreboard;
		alu_result_t pending[$];
		int mismatches;
		int checked;

		function void note_word(logic [3:0] act, logic [31:0] a, logic [31:0] b);
			pending.push_back(alu_predict(act, a, b));
		endfunction

		function void check_word(alu_result_t got);
			alu_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", got);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: value exp %h got %h, cmp exp %b got %b, err exp %b got %b",
						want.value, got.value, want.cmp, got.cmp, want.err, got.err);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	alu_scoreboard board = new();
	int  idle_cycles = 0;
	bit  hold_off = 1'b0;
	bit  stall_pattern = 1'b1;
	int  long_holds = 0;

	q24_8_fixed_point_alu_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // operand_a, operand_b
		.s_tuser  (s_tuser),   // action
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // result_value, compare_true, divide_error, pad
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Sample handshakes at the rising edge; feed the scoreboard and the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_word(s_tuser, s_tdata[31:0], s_tdata[63:32]);
			if (m_tvalid && m_tready)
				board.check_word({m_tdata[31:0], m_tdata[32], m_tdata[33]});
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(!s_tvalid && board.pending.size() == 0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", board.pending.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Receiver: stall on its own random pattern, always accept when the pattern is off, or hold off entirely on request.
	always @(negedge clk) begin
		if (hold_off || !arst_n)
			m_tready <= 1'b0;
		else if (stall_pattern)
			m_tready <= ($urandom_range(0, 3) != 0);
		else
			m_tready <= 1'b1;
	end

	// Long hold-off: stop draining for as long as the caller asks, so the input side backs up.
	task automatic hold_receiver(int cycles);
		long_holds++;
		hold_off = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off = 1'b0;
	endtask

	// Offer one word and wait for it to be taken; valid stays high into the next.
	task automatic send_word(logic [3:0] act, logic [31:0] a, logic [31:0] b);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {b, a};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic pause_sender(int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Drain: wait for every outstanding result, then let the pipe settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Operand biased toward edges, small values and whole numbers.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return MAX_POS;
			1: return MAX_NEG;
			2: return 32'($urandom_range(0, 3)) - 32'd1;
			3: return 32'(signed'($urandom_range(0, 2000)) - 1000);
			4: return 32'(signed'($urandom_range(0, 200)) - 100) << FB;
			5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	logic [31:0] corners[6] = '{32'h0, 32'h1, MAX_POS, MAX_NEG, 32'hFFFF_FFFF, 32'h0000_0100};
	int burst;
	int sent;

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: every action once on overflow-prone corners, then special cases.
		for (int act = 0; act < 16; act++)
			send_word(4'(act), corners[act % 6], corners[(act + 3) % 6]);
		send_word(ACT_DIV, 32'h0000_0500, 32'h0);            // divide by zero
		send_word(ACT_MUL, MAX_POS, MAX_POS);                 // positive saturation
		send_word(ACT_MUL, MAX_NEG, MAX_POS);                 // negative saturation
		send_word(ACT_MUL, 32'hFFFF_FF80, 32'h0000_0001);     // rounding of a half
		send_word(ACT_DIV, MAX_NEG, 32'hFFFF_FFFF);           // divide overflow
		send_word(ACT_DIV, 32'h0000_0001, 32'h0000_0002);     // quotient exactly half
		send_word(ACT_TO_INT, 32'hFFFF_FF01, 32'h0);          // floor of a negative
		send_word(ACT_EQ, MAX_NEG, MAX_NEG);
		send_word(ACT_INC, MAX_POS, 32'h0);                   // wrap on increment
		drain_results();

		// Random bursts; halfway, hold the receiver off while the sender keeps going.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if (sent >= RANDOM_WORDS / 2 && long_holds == 0)
				fork
					hold_receiver(300);
				join_none
			if (sent >= 3 * RANDOM_WORDS / 4 && sent < 3 * RANDOM_WORDS / 4 + 40) begin
				stall_pattern = 1'b0;
				drain_results();
				stall_pattern = 1'b1;
			end
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst; i++) begin
				send_word(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
				sent++;
			end
			if ($urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 12));
		end
		drain_results();

		$display("covered %0d results: all sixteen actions, saturation, rounding, divide by zero,",
			board.checked);
		$display("random bursts with output stalls and %0d long hold-off(s)", long_holds);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
